>>> sv/sat_pkg.sv
// Shared types and constants for the score sorter.
// Used by sat_store, sat_ctrl and sort_ascending_and_top_five; no dependencies.
`default_nettype none

package sat_pkg;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned TOP_COUNT = 5;
  localparam int unsigned SCORE_W   = 14;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  // top run never longer than the store
  localparam int unsigned TOP_CLIP  = (TOP_COUNT < CAPACITY) ? TOP_COUNT : CAPACITY;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               final_item;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] sorted_score;
    logic               run_kind;
    logic               end_of_run;
  } out_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [SCORE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    out_t item;
  } emit_t;

endpackage

`default_nettype wire

>>> sv/sat_store.sv
// Score store: one write port and one registered read port.
// Depends on sat_pkg.
`default_nettype none

module sat_store (
  input  wire                               clk_i,
  input  wire sat_pkg::mem_req_t            mem_req_i,
  output logic [sat_pkg::SCORE_W-1:0]       rdata_o
);

  logic [sat_pkg::SCORE_W-1:0] mem [sat_pkg::CAPACITY];
  logic [sat_pkg::SCORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    // read data holds until the next read
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/sat_ctrl.sv
// Sequencer: insertion on load through one shared comparator, then the
// ascending and descending read-out walks. Depends on sat_pkg.
`default_nettype none

module sat_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire sat_pkg::in_t            in_req_i,
  output sat_pkg::mem_req_t            mem_req_o,
  input  wire [sat_pkg::SCORE_W-1:0]   rdata_i,
  output sat_pkg::emit_t               emit_o,
  input  wire                          slot_free_i
);

  localparam int unsigned AW = sat_pkg::ADDR_W;
  localparam int unsigned CW = sat_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_OUT_RD,
    S_OUT_WR
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               hole_q, hole_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        phase_q, phase_d;
  logic                        final_q, final_d;
  logic [sat_pkg::SCORE_W-1:0] key_q, key_d;

  logic          accept;
  logic          greater;
  logic [CW-1:0] top_len;
  logic [CW-1:0] desc_idx;
  logic          asc_last;
  logic          top_last;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign greater  = rdata_i > key_q;
  assign top_len  = (count_q < CW'(sat_pkg::TOP_CLIP)) ? count_q : CW'(sat_pkg::TOP_CLIP);
  assign desc_idx = count_q - CW'(1) - CW'(idx_q);
  assign asc_last = CW'(idx_q) == (count_q - CW'(1));
  assign top_last = CW'(idx_q) == (top_len - CW'(1));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    hole_d  = hole_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    final_d = final_q;
    key_d   = key_q;

    mem_req_o       = '0;
    emit_o          = '0;
    emit_o.item.sorted_score = rdata_i;
    emit_o.item.run_kind     = phase_q;
    emit_o.item.end_of_run   = phase_q && top_last;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d   = in_req_i.score;
          final_d = in_req_i.final_item;
          idx_d   = '0;
          phase_d = 1'b0;
          if (count_q < CW'(sat_pkg::CAPACITY)) begin
            hole_d  = count_q[AW-1:0];
            count_d = count_q + CW'(1);
            state_d = S_INS_RD;
          end else if (in_req_i.final_item) begin
            // store full: dropped, but the set still closes
            state_d = S_OUT_RD;
          end
        end
      end
      S_INS_RD: begin
        if (hole_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = hole_q;
          mem_req_o.wdata = key_q;
          state_d = final_q ? S_OUT_RD : S_IDLE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = hole_q - AW'(1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hole_q;
        if (greater) begin
          mem_req_o.wdata = rdata_i;
          hole_d  = hole_q - AW'(1);
          state_d = S_INS_RD;
        end else begin
          mem_req_o.wdata = key_q;
          state_d = final_q ? S_OUT_RD : S_IDLE;
        end
      end
      S_OUT_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = phase_q ? desc_idx[AW-1:0] : idx_q;
        state_d = S_OUT_WR;
      end
      S_OUT_WR: begin
        emit_o.valid = 1'b1;
        if (slot_free_i) begin
          state_d = S_OUT_RD;
          idx_d   = idx_q + AW'(1);
          if (!phase_q && asc_last) begin
            phase_d = 1'b1;
            idx_d   = '0;
          end else if (phase_q && top_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      hole_q  <= '0;
      idx_q   <= '0;
      phase_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hole_q  <= hole_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(sat_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_INS_RD || state_q == S_INS_CMP))
    else $error("store written outside insertion");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_RD) |-> (CW'(idx_q) < count_q))
    else $error("read-out index beyond stored count");

  a_end_closes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.item.end_of_run && slot_free_i)
      |=> (state_q == S_IDLE && count_q == '0))
    else $error("set not closed after last result");
`endif

endmodule

`default_nettype wire

>>> sv/sort_ascending_and_top_five.sv
// Top level of the score sorter; depends on sat_pkg, sat_store and sat_ctrl.
// Insert: a score enters at the end, larger stored ones are read, compared and shifted up,
// until its place is found; a score is dropped if the store is full. A final score inserts
// likewise, then the m stored scores ascending and min(m,5) descending results follow,
// each by a store read, then an output register load. New requests wait for idle.
// Reset (async, active low) empties the set; store contents are not cleared.
`default_nettype none

module sort_ascending_and_top_five (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire sat_pkg::in_t in_req_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output sat_pkg::out_t  out_req_o
);

  sat_pkg::mem_req_t           mem_req;
  logic [sat_pkg::SCORE_W-1:0] rdata;
  sat_pkg::emit_t              emit;
  logic                        slot_free;

  logic          out_valid_q, out_valid_d;
  sat_pkg::out_t out_req_q, out_req_d;

  assign slot_free = !out_valid_q || out_ready_i;

  sat_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  sat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .emit_o      (emit),
    .slot_free_i (slot_free)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    if (slot_free) begin
      out_valid_d = emit.valid;
      if (emit.valid) begin
        out_req_d = emit.item;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire
